// ===== rtl/stepper_ramp_pulse_generator_assert.svh =====
// Assertion macros for the stepper ramp pulse generator.
`ifndef STEPPER_RAMP_PULSE_GENERATOR_ASSERT_SVH
`define STEPPER_RAMP_PULSE_GENERATOR_ASSERT_SVH

`ifndef SYNTH
// Same-cycle implication, checked outside reset.
`define SRPG_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// Next-cycle implication, checked outside reset.
`define SRPG_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define SRPG_ASSERT_SAME(lbl, clk, rst, ante, cons)
`define SRPG_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif

`endif

// ===== rtl/srpg_pkg.sv =====
// Shared types and constants of the stepper ramp pulse generator.
`timescale 1ns / 1ps
`default_nettype none

package srpg_pkg;

   localparam int SPEED_W  = 24;
   localparam int CFG_W    = 16;
   localparam int ACTION_W = 3;
   localparam int CSR_IDX_W = 2;

   localparam int DEFAULT_SPEED_FRAC_BITS = 8;
   localparam int DEFAULT_TIME_WIDTH      = 32;

   // 60e6 / 2: half the microseconds in a minute, for the half period of one step.
   localparam int unsigned RPM_HALF_US = 30000000;
   localparam int RPM_HALF_W = 25;

   localparam logic [CFG_W-1:0] TICK_PERIOD_RESET = 16'd100;
   localparam logic [CFG_W-1:0] PULSES_REV_RESET  = 16'd200;
   localparam logic [CFG_W-1:0] ACCEL_STEP_RESET  = 16'd0;
   localparam logic             CONTINUOUS_RESET  = 1'b1;

   typedef enum logic [ACTION_W-1:0] {
      ACT_TICK  = 3'd0,
      ACT_START = 3'd1,
      ACT_HOLD  = 3'd2,
      ACT_STOP  = 3'd3,
      ACT_SET   = 3'd4
   } action_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_TICK_PERIOD = 2'd0,
      CSR_PULSES_REV  = 2'd1,
      CSR_ACCEL_STEP  = 2'd2,
      CSR_CONTINUOUS  = 2'd3
   } csr_reg_type;

endpackage

`default_nettype wire

// ===== rtl/stepper_ramp_pulse_generator.sv =====
// Stepper ramp pulse generator: one request in, one pin/speed snapshot out.
// The req channel carries an action (tick, start, hold, stop, set speed) and
// a Q16.8 signed target speed. Each request yields exactly one response on
// the rsp channel with the enable, direction and step pin levels, the ramped
// speed and the running flag as they stand after the request.
// The csr channel writes tick period, pulses per revolution, acceleration
// step and continuous mode and is always ready. The user must see that it
// is written only while idle; the block itself does not enforce this.
// Commands and idle ticks pass through the execute and output states. A
// tick that moves the motor at nonzero speed also passes the multiply,
// divide and compare states; in the divide state the one-bit-per-cycle
// restoring divider forms the step half period. One request is in work at
// a time, so a new request is taken only once the last has left the output state.
// A finished response waits in an output register, so the next request is
// accepted while the receiver stalls; a new response waits for that
// register to be taken. Synchronous reset loads the register defaults,
// stops the motor with the driver disabled and drops any pending response.
`timescale 1ns / 1ps
`default_nettype none
`include "stepper_ramp_pulse_generator_assert.svh"

module stepper_ramp_pulse_generator #(
   parameter int SPEED_FRAC_BITS = srpg_pkg::DEFAULT_SPEED_FRAC_BITS,
   parameter int TIME_WIDTH      = srpg_pkg::DEFAULT_TIME_WIDTH
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_ready,
   input  wire logic [srpg_pkg::ACTION_W-1:0]      req_action,
   input  wire logic signed [srpg_pkg::SPEED_W-1:0] req_speed_value,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_ready,
   output logic                                    rsp_enable_level,
   output logic                                    rsp_direction_level,
   output logic                                    rsp_pulse_level,
   output logic signed [srpg_pkg::SPEED_W-1:0]     rsp_current_speed,
   output logic                                    rsp_is_running,
   input  wire logic                               csr_valid,
   output logic                                    csr_ready,
   input  wire logic [srpg_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [srpg_pkg::CFG_W-1:0]         csr_wdata
);
   import srpg_pkg::*;

   localparam int NUM_W  = RPM_HALF_W + SPEED_FRAC_BITS;
   localparam int DEN_W  = CFG_W + SPEED_W;
   localparam int CNT_W  = $clog2(NUM_W);
   localparam int WIDE_W = (NUM_W > TIME_WIDTH) ? NUM_W : TIME_WIDTH;
   localparam logic [NUM_W-1:0] HALF_NUM = NUM_W'(RPM_HALF_US) << SPEED_FRAC_BITS;
   localparam logic [TIME_WIDTH-1:0] TIME_MAX = {TIME_WIDTH{1'b1}};

   typedef enum logic [5:0] {
      ST_IDLE = 6'b000001,
      ST_EXEC = 6'b000010,
      ST_MULT = 6'b000100,
      ST_DIV  = 6'b001000,
      ST_CMP  = 6'b010000,
      ST_OUT  = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   logic [CFG_W-1:0] tick_period_ff, tick_period_in;
   logic [CFG_W-1:0] pulses_rev_ff, pulses_rev_in;
   logic [CFG_W-1:0] accel_step_ff, accel_step_in;
   logic             continuous_ff, continuous_in;

   logic                      running_ff, running_in;
   logic signed [SPEED_W-1:0] speed_now_ff, speed_now_in;
   logic signed [SPEED_W-1:0] speed_goal_ff, speed_goal_in;
   logic [TIME_WIDTH-1:0]     elapsed_ff, elapsed_in;
   logic                      enable_pin_ff, enable_pin_in;
   logic                      direction_pin_ff, direction_pin_in;
   logic                      pulse_pin_ff, pulse_pin_in;

   logic [ACTION_W-1:0]       action_ff, action_in;
   logic signed [SPEED_W-1:0] speed_val_ff, speed_val_in;
   logic [DEN_W-1:0]          den_ff, den_in;
   logic [DEN_W-1:0]          rem_ff, rem_in;
   logic [NUM_W-1:0]          quot_ff, quot_in;
   logic [CNT_W-1:0]          cnt_ff, cnt_in;

   logic                      rsp_valid_ff, rsp_valid_in;
   logic                      rsp_enable_ff, rsp_enable_in;
   logic                      rsp_direction_ff, rsp_direction_in;
   logic                      rsp_pulse_ff, rsp_pulse_in;
   logic signed [SPEED_W-1:0] rsp_speed_ff, rsp_speed_in;
   logic                      rsp_running_ff, rsp_running_in;

   // Ramp and accumulator arithmetic for a tick.
   logic signed [SPEED_W:0]   now_x, goal_x, accel_x, speed_up, speed_dn;
   logic signed [SPEED_W-1:0] speed_ramp;
   logic [TIME_WIDTH:0]       elapsed_sum;
   logic [TIME_WIDTH-1:0]     elapsed_tick;
   logic [SPEED_W-1:0]        speed_mag;
   logic [DEN_W:0]            trial, trial_diff;
   logic                      trial_ge;
   logic [WIDE_W-1:0]         quot_wide;
   logic [TIME_WIDTH-1:0]     wait_time;

   always_comb begin
      now_x    = {speed_now_ff[SPEED_W-1], speed_now_ff};
      goal_x   = {speed_goal_ff[SPEED_W-1], speed_goal_ff};
      accel_x  = signed'({{(SPEED_W+1-CFG_W){1'b0}}, accel_step_ff});
      speed_up = now_x + accel_x;
      speed_dn = now_x - accel_x;
      if (accel_step_ff == '0) begin
         speed_ramp = speed_now_ff;
      end else if (now_x < goal_x) begin
         speed_ramp = (speed_up > goal_x) ? speed_goal_ff : speed_up[SPEED_W-1:0];
      end else if (now_x > goal_x) begin
         speed_ramp = (speed_dn < goal_x) ? speed_goal_ff : speed_dn[SPEED_W-1:0];
      end else begin
         speed_ramp = speed_now_ff;
      end

      elapsed_sum  = {1'b0, elapsed_ff} + (TIME_WIDTH+1)'(tick_period_ff);
      elapsed_tick = elapsed_sum[TIME_WIDTH] ? TIME_MAX : elapsed_sum[TIME_WIDTH-1:0];

      speed_mag = speed_now_ff[SPEED_W-1] ? SPEED_W'(-speed_now_ff) : speed_now_ff;

      // One restoring division step: bring down the next dividend bit.
      trial      = {rem_ff, quot_ff[NUM_W-1]};
      trial_diff = trial - {1'b0, den_ff};
      trial_ge   = (trial >= {1'b0, den_ff});

      quot_wide = WIDE_W'(quot_ff);
      if (den_ff == '0 || quot_wide > WIDE_W'(TIME_MAX)) begin
         wait_time = TIME_MAX;
      end else begin
         wait_time = quot_wide[TIME_WIDTH-1:0];
      end
   end

   always_comb begin
      state_in         = state_ff;
      tick_period_in   = tick_period_ff;
      pulses_rev_in    = pulses_rev_ff;
      accel_step_in    = accel_step_ff;
      continuous_in    = continuous_ff;
      running_in       = running_ff;
      speed_now_in     = speed_now_ff;
      speed_goal_in    = speed_goal_ff;
      elapsed_in       = elapsed_ff;
      enable_pin_in    = enable_pin_ff;
      direction_pin_in = direction_pin_ff;
      pulse_pin_in     = pulse_pin_ff;
      action_in        = action_ff;
      speed_val_in     = speed_val_ff;
      den_in           = den_ff;
      rem_in           = rem_ff;
      quot_in          = quot_ff;
      cnt_in           = cnt_ff;
      rsp_valid_in     = rsp_valid_ff;
      rsp_enable_in    = rsp_enable_ff;
      rsp_direction_in = rsp_direction_ff;
      rsp_pulse_in     = rsp_pulse_ff;
      rsp_speed_in     = rsp_speed_ff;
      rsp_running_in   = rsp_running_ff;

      if (csr_valid) begin
         case (csr_index)
            CSR_TICK_PERIOD: tick_period_in = csr_wdata;
            CSR_PULSES_REV:  pulses_rev_in  = csr_wdata;
            CSR_ACCEL_STEP:  accel_step_in  = csr_wdata;
            CSR_CONTINUOUS:  continuous_in  = csr_wdata[0];
            default: ;
         endcase
      end

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               action_in    = req_action;
               speed_val_in = req_speed_value;
               state_in     = ST_EXEC;
            end
         end
         ST_EXEC: begin
            state_in = ST_OUT;
            case (action_ff)
               ACT_TICK: begin
                  if (running_ff && continuous_ff) begin
                     elapsed_in       = elapsed_tick;
                     speed_now_in     = speed_ramp;
                     direction_pin_in = ~speed_ramp[SPEED_W-1];
                     if (speed_ramp != '0) begin
                        state_in = ST_MULT;
                     end
                  end
               end
               ACT_START: begin
                  running_in       = 1'b1;
                  enable_pin_in    = 1'b0;
                  direction_pin_in = 1'b1;
               end
               ACT_HOLD: begin
                  running_in       = 1'b0;
                  speed_now_in     = '0;
                  enable_pin_in    = 1'b0;
                  direction_pin_in = 1'b1;
                  pulse_pin_in     = 1'b0;
               end
               ACT_STOP: begin
                  running_in       = 1'b0;
                  speed_now_in     = '0;
                  enable_pin_in    = 1'b1;
                  direction_pin_in = 1'b0;
                  pulse_pin_in     = 1'b0;
               end
               ACT_SET: begin
                  speed_goal_in = speed_val_ff;
                  if (accel_step_ff == '0) begin
                     speed_now_in = speed_val_ff;
                  end
               end
               default: ;
            endcase
         end
         ST_MULT: begin
            den_in   = DEN_W'(pulses_rev_ff * speed_mag);
            rem_in   = '0;
            quot_in  = HALF_NUM;
            cnt_in   = CNT_W'(NUM_W - 1);
            state_in = ST_DIV;
         end
         ST_DIV: begin
            rem_in  = trial_ge ? trial_diff[DEN_W-1:0] : trial[DEN_W-1:0];
            quot_in = {quot_ff[NUM_W-2:0], trial_ge};
            if (cnt_ff == '0) begin
               state_in = ST_CMP;
            end else begin
               cnt_in = cnt_ff - 1'b1;
            end
         end
         ST_CMP: begin
            if (elapsed_ff >= wait_time) begin
               elapsed_in   = '0;
               pulse_pin_in = ~pulse_pin_ff;
            end
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in     = 1'b1;
               rsp_enable_in    = enable_pin_ff;
               rsp_direction_in = direction_pin_ff;
               rsp_pulse_in     = pulse_pin_ff;
               rsp_speed_in     = speed_now_ff;
               rsp_running_in   = running_ff;
               state_in         = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_IDLE;
         tick_period_ff   <= TICK_PERIOD_RESET;
         pulses_rev_ff    <= PULSES_REV_RESET;
         accel_step_ff    <= ACCEL_STEP_RESET;
         continuous_ff    <= CONTINUOUS_RESET;
         running_ff       <= 1'b0;
         speed_now_ff     <= '0;
         speed_goal_ff    <= '0;
         elapsed_ff       <= '0;
         enable_pin_ff    <= 1'b1;
         direction_pin_ff <= 1'b0;
         pulse_pin_ff     <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         state_ff         <= state_in;
         tick_period_ff   <= tick_period_in;
         pulses_rev_ff    <= pulses_rev_in;
         accel_step_ff    <= accel_step_in;
         continuous_ff    <= continuous_in;
         running_ff       <= running_in;
         speed_now_ff     <= speed_now_in;
         speed_goal_ff    <= speed_goal_in;
         elapsed_ff       <= elapsed_in;
         enable_pin_ff    <= enable_pin_in;
         direction_pin_ff <= direction_pin_in;
         pulse_pin_ff     <= pulse_pin_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      action_ff        <= action_in;
      speed_val_ff     <= speed_val_in;
      den_ff           <= den_in;
      rem_ff           <= rem_in;
      quot_ff          <= quot_in;
      cnt_ff           <= cnt_in;
      rsp_enable_ff    <= rsp_enable_in;
      rsp_direction_ff <= rsp_direction_in;
      rsp_pulse_ff     <= rsp_pulse_in;
      rsp_speed_ff     <= rsp_speed_in;
      rsp_running_ff   <= rsp_running_in;
   end

   assign req_ready           = (state_ff == ST_IDLE);
   assign csr_ready           = 1'b1;
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_enable_level    = rsp_enable_ff;
   assign rsp_direction_level = rsp_direction_ff;
   assign rsp_pulse_level     = rsp_pulse_ff;
   assign rsp_current_speed   = rsp_speed_ff;
   assign rsp_is_running      = rsp_running_ff;

   `SRPG_ASSERT_NEXT(a_accept_exec, clock, reset, req_valid && req_ready, state_ff == ST_EXEC)
   `SRPG_ASSERT_SAME(a_dir_sign, clock, reset, state_ff == ST_CMP,
                     direction_pin_ff == !speed_now_ff[SPEED_W-1])
   `SRPG_ASSERT_NEXT(a_stop_off, clock, reset, state_ff == ST_EXEC && action_ff == ACT_STOP,
                     enable_pin_ff && !running_ff && !pulse_pin_ff && speed_now_ff == '0)

endmodule

`default_nettype wire

// ===== test/tb_top.sv =====
// Testbench for the stepper ramp pulse generator: directed and random requests, self-checked.
`timescale 1ns / 1ps

module tb_top;
   import srpg_pkg::*;

   localparam int SETTLE_CYCLES = 64;
   localparam int PRINT_LIMIT = 40;
   localparam longint TIME_LIMIT = (longint'(1) << DEFAULT_TIME_WIDTH) - 1;
   localparam longint HALF_NUMERATOR = longint'(RPM_HALF_US) << DEFAULT_SPEED_FRAC_BITS;
   localparam logic signed [SPEED_W-1:0] SPEED_MAX = 24'sh7FFFFF;
   localparam logic signed [SPEED_W-1:0] SPEED_MIN = 24'sh800000;

   typedef enum {IDLE_NONE, IDLE_SPARSE, IDLE_FULL} idle_style_type;

   typedef struct packed {
      logic [ACTION_W-1:0]        action;
      logic signed [SPEED_W-1:0]  speed;
   } motor_request_type;

   typedef struct packed {
      logic                       en;
      logic                       dir;
      logic                       pulse;
      logic signed [SPEED_W-1:0]  speed;
      logic                       running;
   } pin_snapshot_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [ACTION_W-1:0] req_action = '0;
   logic signed [SPEED_W-1:0] req_speed_value = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic rsp_enable_level;
   logic rsp_direction_level;
   logic rsp_pulse_level;
   logic signed [SPEED_W-1:0] rsp_current_speed;
   logic rsp_is_running;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CFG_W-1:0] csr_wdata = '0;

   motor_request_type requests_pending[$];
   pin_snapshot_type snapshots_due[$];
   pin_snapshot_type snapshot_seen;
   idle_style_type sender_style = IDLE_FULL;
   idle_style_type receiver_style = IDLE_FULL;
   int req_gap = 0;
   int rsp_stall = 0;
   int mismatch_count = 0;
   int rsp_count = 0;

   // Model copy of the configuration and motor state.
   longint cfg_tick = TICK_PERIOD_RESET;
   longint cfg_ppr = PULSES_REV_RESET;
   longint cfg_accel = ACCEL_STEP_RESET;
   bit cfg_cont = CONTINUOUS_RESET;
   bit run_flag = 1'b0;
   longint spd_now = 0;
   longint spd_goal = 0;
   longint elapsed = 0;
   bit en_pin = 1'b1;
   bit dir_pin = 1'b0;
   bit pulse_pin = 1'b0;

   stepper_ramp_pulse_generator dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_action(req_action),
      .req_speed_value(req_speed_value),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_enable_level(rsp_enable_level),
      .rsp_direction_level(rsp_direction_level),
      .rsp_pulse_level(rsp_pulse_level),
      .rsp_current_speed(rsp_current_speed),
      .rsp_is_running(rsp_is_running),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int draw_wait(idle_style_type style);
      case (style)
         IDLE_NONE: return 0;
         IDLE_SPARSE: return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 19) : 0;
         default: return $urandom_range(0, 19);
      endcase
   endfunction

   function automatic logic signed [SPEED_W-1:0] random_speed();
      int unsigned width;
      int unsigned mag;
      case ($urandom_range(0, 5))
         0: return SPEED_W'($urandom);
         1: return $urandom_range(0, 1) ? SPEED_MAX : SPEED_MIN;
         default: begin
            width = $urandom_range(1, SPEED_W - 1);
            mag = $urandom & ((32'd1 << width) - 1);
            return $urandom_range(0, 1) ? SPEED_W'(0 - mag) : SPEED_W'(mag);
         end
      endcase
   endfunction

   task automatic report_mismatch(input string what);
      if (mismatch_count < PRINT_LIMIT)
         $display("ERROR %0t ns, response %0d: %s", $time, rsp_count, what);
      mismatch_count++;
   endtask

   // Applies one accepted request to the motor state and queues the pin snapshot it leaves.
   task automatic predict_request(input logic [ACTION_W-1:0] act,
                                  input logic signed [SPEED_W-1:0] target);
      longint mag;
      longint den;
      longint half;
      pin_snapshot_type snap;
      case (act)
         ACT_TICK: begin
            if (run_flag && cfg_cont) begin
               elapsed = elapsed + cfg_tick;
               if (elapsed > TIME_LIMIT)
                  elapsed = TIME_LIMIT;
               if (cfg_accel != 0) begin
                  if (spd_now < spd_goal) begin
                     spd_now = spd_now + cfg_accel;
                     if (spd_now > spd_goal)
                        spd_now = spd_goal;
                  end else if (spd_now > spd_goal) begin
                     spd_now = spd_now - cfg_accel;
                     if (spd_now < spd_goal)
                        spd_now = spd_goal;
                  end
               end
               dir_pin = (spd_now >= 0);
               if (spd_now != 0) begin
                  mag = (spd_now < 0) ? -spd_now : spd_now;
                  den = cfg_ppr * mag;
                  half = (den == 0) ? TIME_LIMIT : HALF_NUMERATOR / den;
                  if (half > TIME_LIMIT)
                     half = TIME_LIMIT;
                  if (elapsed >= half) begin
                     elapsed = 0;
                     pulse_pin = ~pulse_pin;
                  end
               end
            end
         end
         ACT_START: begin
            run_flag = 1'b1;
            en_pin = 1'b0;
            dir_pin = 1'b1;
         end
         ACT_HOLD: begin
            run_flag = 1'b0;
            spd_now = 0;
            en_pin = 1'b0;
            dir_pin = 1'b1;
            pulse_pin = 1'b0;
         end
         ACT_STOP: begin
            run_flag = 1'b0;
            spd_now = 0;
            en_pin = 1'b1;
            dir_pin = 1'b0;
            pulse_pin = 1'b0;
         end
         ACT_SET: begin
            spd_goal = target;
            if (cfg_accel == 0)
               spd_now = spd_goal;
         end
         default: ;
      endcase
      snap.en = en_pin;
      snap.dir = dir_pin;
      snap.pulse = pulse_pin;
      snap.speed = spd_now[SPEED_W-1:0];
      snap.running = run_flag;
      snapshots_due.push_back(snap);
   endtask

   // Request driver.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_gap = 0;
      end else begin
         if (!req_valid || req_ready) begin
            if (req_valid) begin
               predict_request(req_action, req_speed_value);
               req_gap = draw_wait(sender_style);
            end
            if (req_gap > 0) begin
               req_gap--;
               req_valid <= 1'b0;
            end else if (requests_pending.size() > 0) begin
               req_valid <= 1'b1;
               req_action <= requests_pending[0].action;
               req_speed_value <= requests_pending[0].speed;
               void'(requests_pending.pop_front());
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Response monitor and receiver stalls.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         rsp_stall = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (snapshots_due.size() == 0) begin
               report_mismatch("response with no request outstanding");
            end else begin
               snapshot_seen = snapshots_due.pop_front();
               if (rsp_enable_level !== snapshot_seen.en)
                  report_mismatch($sformatf("enable_level got %b want %b",
                                            rsp_enable_level, snapshot_seen.en));
               if (rsp_direction_level !== snapshot_seen.dir)
                  report_mismatch($sformatf("direction_level got %b want %b",
                                            rsp_direction_level, snapshot_seen.dir));
               if (rsp_pulse_level !== snapshot_seen.pulse)
                  report_mismatch($sformatf("pulse_level got %b want %b",
                                            rsp_pulse_level, snapshot_seen.pulse));
               if (rsp_current_speed !== snapshot_seen.speed)
                  report_mismatch($sformatf("current_speed got %0d want %0d",
                                            rsp_current_speed, snapshot_seen.speed));
               if (rsp_is_running !== snapshot_seen.running)
                  report_mismatch($sformatf("is_running got %b want %b",
                                            rsp_is_running, snapshot_seen.running));
            end
            rsp_count++;
            rsp_stall = draw_wait(receiver_style);
         end
         if (rsp_stall > 0) begin
            rsp_stall--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   task automatic push_request(input logic [ACTION_W-1:0] act,
                               input logic signed [SPEED_W-1:0] target);
      motor_request_type item;
      item.action = act;
      item.speed = target;
      requests_pending.push_back(item);
   endtask

   task automatic write_csr(input csr_reg_type idx, input logic [CFG_W-1:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         CSR_TICK_PERIOD: cfg_tick = value;
         CSR_PULSES_REV: cfg_ppr = value;
         CSR_ACCEL_STEP: cfg_accel = value;
         CSR_CONTINUOUS: cfg_cont = value[0];
         default: ;
      endcase
   endtask

   task automatic write_config(input logic [CFG_W-1:0] tick, input logic [CFG_W-1:0] ppr,
                               input logic [CFG_W-1:0] accel, input bit cont);
      write_csr(CSR_TICK_PERIOD, tick);
      write_csr(CSR_PULSES_REV, ppr);
      write_csr(CSR_ACCEL_STEP, accel);
      write_csr(CSR_CONTINUOUS, {{(CFG_W - 1){1'b0}}, cont});
   endtask

   // Waits until every request is out and answered, then lets the block settle.
   task automatic drain_block();
      while (requests_pending.size() > 0 || req_valid || snapshots_due.size() > 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // A run from start: mostly ticks, with speed changes and the odd command or spare code.
   task automatic queue_random_burst();
      int len;
      if ($urandom_range(0, 1))
         push_request(ACT_SET, random_speed());
      push_request(ACT_START, '0);
      len = $urandom_range(4, 30);
      repeat (len) begin
         case ($urandom_range(0, 19))
            14, 15: push_request(ACT_SET, random_speed());
            16: push_request(ACT_HOLD, SPEED_W'($urandom));
            17: push_request(ACT_STOP, SPEED_W'($urandom));
            18: push_request(ACT_START, SPEED_W'($urandom));
            19: push_request(ACTION_W'($urandom_range(ACT_SET + 1, (1 << ACTION_W) - 1)),
                             SPEED_W'($urandom));
            default: push_request(ACT_TICK, SPEED_W'($urandom));
         endcase
      end
      case ($urandom_range(0, 2))
         0: push_request(ACT_HOLD, '0);
         1: push_request(ACT_STOP, '0);
         default: ;
      endcase
   endtask

   initial begin
      logic [CFG_W-1:0] tick_pick;
      logic [CFG_W-1:0] ppr_pick;
      logic [CFG_W-1:0] accel_pick;

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Reset configuration: idle tick, spare codes, instant speed at both extremes,
      // hold and stop, zero speed and a slow speed that never reaches its half period.
      push_request(ACT_TICK, '0);
      for (int a = ACT_SET + 1; a < (1 << ACTION_W); a++)
         push_request(ACTION_W'(a), SPEED_MAX);
      push_request(ACT_SET, SPEED_MAX);
      push_request(ACT_START, '0);
      push_request(ACT_TICK, '0);
      push_request(ACT_TICK, '0);
      push_request(ACT_SET, SPEED_MIN);
      push_request(ACT_TICK, '0);
      push_request(ACT_HOLD, '0);
      push_request(ACT_TICK, '0);
      push_request(ACT_START, '0);
      push_request(ACT_SET, '0);
      push_request(ACT_TICK, '0);
      push_request(ACT_SET, 24'sd256);
      push_request(ACT_TICK, '0);
      push_request(ACT_STOP, '0);
      drain_block();

      // Zero pulses per revolution with a ramp that overshoots and clamps.
      write_config(16'hFFFF, 16'd0, 16'hFFFF, 1'b1);
      push_request(ACT_SET, 24'sd5000);
      push_request(ACT_START, '0);
      push_request(ACT_TICK, '0);
      push_request(ACT_SET, -24'sd3000);
      push_request(ACT_TICK, '0);
      push_request(ACT_STOP, '0);
      drain_block();

      // Ticks ignored outside continuous mode, then a one-step ramp with a zero period.
      write_config(16'd0, 16'hFFFF, 16'd1, 1'b0);
      push_request(ACT_START, '0);
      push_request(ACT_SET, -24'sd2);
      push_request(ACT_TICK, '0);
      drain_block();
      write_csr(CSR_CONTINUOUS, 16'd1);
      push_request(ACT_TICK, '0);
      push_request(ACT_TICK, '0);
      push_request(ACT_TICK, '0);
      push_request(ACT_HOLD, '0);
      drain_block();

      for (int phase = 0; phase < 6; phase++) begin
         sender_style = idle_style_type'($urandom_range(0, 2));
         receiver_style = idle_style_type'($urandom_range(0, 2));
         case ($urandom_range(0, 4))
            0: tick_pick = 16'd1;
            1: tick_pick = 16'hFFFF;
            2: tick_pick = 16'd100;
            3: tick_pick = CFG_W'($urandom_range(1, 2000));
            default: tick_pick = CFG_W'($urandom);
         endcase
         case ($urandom_range(0, 7))
            0: ppr_pick = 16'd0;
            1: ppr_pick = 16'd1;
            2: ppr_pick = 16'hFFFF;
            3: ppr_pick = 16'd200;
            4, 5: ppr_pick = CFG_W'($urandom_range(1, 400));
            default: ppr_pick = CFG_W'($urandom);
         endcase
         case ($urandom_range(0, 5))
            0, 1: accel_pick = 16'd0;
            2: accel_pick = 16'hFFFF;
            3: accel_pick = CFG_W'($urandom_range(1, 64));
            4: accel_pick = CFG_W'($urandom_range(64, 4096));
            default: accel_pick = CFG_W'($urandom);
         endcase
         write_config(tick_pick, ppr_pick, accel_pick, $urandom_range(0, 5) != 0);
         while (requests_pending.size() < 50)
            queue_random_burst();
         drain_block();
      end

      // The slowest speed with one pulse per revolution, whose half period saturates.
      sender_style = IDLE_NONE;
      receiver_style = IDLE_NONE;
      write_config(16'hFFFF, 16'd1, 16'd0, 1'b1);
      push_request(ACT_SET, 24'sd1);
      push_request(ACT_START, '0);
      push_request(ACT_TICK, '0);
      push_request(ACT_TICK, '0);
      push_request(ACT_STOP, '0);
      drain_block();

      if (mismatch_count == 0) begin
         $display("** stepper_ramp_pulse_generator: PASSED **");
      end else begin
         $display("** stepper_ramp_pulse_generator: FAILED **");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("TIMEOUT with %0d requests pending and %0d responses due",
               requests_pending.size(), snapshots_due.size());
      $display("** stepper_ramp_pulse_generator: FAILED **");
      $finish;
   end

endmodule
